@@ sv/wmrdtb_pkg.sv @@
// ----------------------------------------------------------------------------
// wmrdtb_pkg
// Shared types and constants for the window mode and drift bias core.
// ----------------------------------------------------------------------------
package wmrdtb_pkg;

    localparam int DEFAULT_DEPTH = 16;
    localparam int DRIFT_W       = 16;
    localparam int ENTRY_W       = 18;
    localparam int SHIFT_W       = 13;
    localparam int CNT_W         = 4;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX = 13'd6553;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_ARITH,
        ST_DIV_LOAD,
        ST_DIV_RUN,
        ST_DIV_STORE,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        OP_POS,
        OP_NEG,
        OP_DIFF,
        OP_NUM,
        OP_DEN_A,
        OP_DEN_B,
        OP_DEN_C
    } t_arith_op;

    typedef enum logic [1:0] {
        DIV_DET,
        DIV_EXP,
        DIV_RISK
    } t_div_sel;

    typedef struct packed {
        logic      load;
        logic      scan_rd;
        logic      arith_en;
        t_arith_op arith_op;
        logic      div_load;
        logic      div_step;
        logic      div_store;
        t_div_sel  div_sel;
        logic      publish;
    } t_cmd;

    typedef struct packed {
        logic scan_last;
    } t_sts;

endpackage

@@ sv/wmrdtb_ctrl.sv @@
// ----------------------------------------------------------------------------
// wmrdtb_ctrl
// Sequencer: window scan, multiply chain, three divisions, result hand-off.
// ----------------------------------------------------------------------------
module wmrdtb_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  wmrdtb_pkg::t_sts   i_sts,
    output wmrdtb_pkg::t_cmd   o_cmd
);

    wmrdtb_pkg::t_state    r_state, n_state;
    wmrdtb_pkg::t_arith_op r_op, n_op;
    wmrdtb_pkg::t_div_sel  r_sel, n_sel;
    logic [wmrdtb_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                  r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wmrdtb_pkg::ST_IDLE;
            r_op        <= wmrdtb_pkg::OP_POS;
            r_sel       <= wmrdtb_pkg::DIV_DET;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_sel       <= n_sel;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_sel       = r_sel;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid & ~i_out_ready;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        o_cmd.arith_op = r_op;
        o_cmd.div_sel  = r_sel;
        unique case (r_state)
            wmrdtb_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = wmrdtb_pkg::ST_SCAN;
                end
            end
            wmrdtb_pkg::ST_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = wmrdtb_pkg::ST_DRAIN;
                end
            end
            wmrdtb_pkg::ST_DRAIN: begin
                n_op    = wmrdtb_pkg::OP_POS;
                n_state = wmrdtb_pkg::ST_ARITH;
            end
            wmrdtb_pkg::ST_ARITH: begin
                o_cmd.arith_en = 1'b1;
                unique case (r_op)
                    wmrdtb_pkg::OP_POS:   n_op = wmrdtb_pkg::OP_NEG;
                    wmrdtb_pkg::OP_NEG:   n_op = wmrdtb_pkg::OP_DIFF;
                    wmrdtb_pkg::OP_DIFF:  n_op = wmrdtb_pkg::OP_NUM;
                    wmrdtb_pkg::OP_NUM:   n_op = wmrdtb_pkg::OP_DEN_A;
                    wmrdtb_pkg::OP_DEN_A: n_op = wmrdtb_pkg::OP_DEN_B;
                    wmrdtb_pkg::OP_DEN_B: n_op = wmrdtb_pkg::OP_DEN_C;
                    default: begin
                        n_op    = wmrdtb_pkg::OP_POS;
                        n_sel   = wmrdtb_pkg::DIV_DET;
                        n_state = wmrdtb_pkg::ST_DIV_LOAD;
                    end
                endcase
            end
            wmrdtb_pkg::ST_DIV_LOAD: begin
                o_cmd.div_load = 1'b1;
                n_cnt          = wmrdtb_pkg::CNT_W'(wmrdtb_pkg::SHIFT_W - 1);
                n_state        = wmrdtb_pkg::ST_DIV_RUN;
            end
            wmrdtb_pkg::ST_DIV_RUN: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = wmrdtb_pkg::ST_DIV_STORE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            wmrdtb_pkg::ST_DIV_STORE: begin
                o_cmd.div_store = 1'b1;
                unique case (r_sel)
                    wmrdtb_pkg::DIV_DET: begin
                        n_sel   = wmrdtb_pkg::DIV_EXP;
                        n_state = wmrdtb_pkg::ST_DIV_LOAD;
                    end
                    wmrdtb_pkg::DIV_EXP: begin
                        n_sel   = wmrdtb_pkg::DIV_RISK;
                        n_state = wmrdtb_pkg::ST_DIV_LOAD;
                    end
                    default: begin
                        n_state = wmrdtb_pkg::ST_DONE;
                    end
                endcase
            end
            wmrdtb_pkg::ST_DONE: begin
                // wait for the output register to free up
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.publish = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = wmrdtb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = wmrdtb_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ sv/wmrdtb_dp.sv @@
// ----------------------------------------------------------------------------
// wmrdtb_dp
// Window memory, scan accumulators, shared multiplier, restoring divider.
// ----------------------------------------------------------------------------
module wmrdtb_dp #(
    parameter int WINDOW_DEPTH = wmrdtb_pkg::DEFAULT_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  wmrdtb_pkg::t_cmd                  i_cmd,
    output wmrdtb_pkg::t_sts                  o_sts,
    input  logic                              i_conservative_flag,
    input  logic                              i_exploratory_flag,
    input  logic [wmrdtb_pkg::DRIFT_W-1:0]    i_drift_score,
    output logic [wmrdtb_pkg::SHIFT_W-1:0]    o_determinism_shift,
    output logic [wmrdtb_pkg::SHIFT_W-1:0]    o_exploration_shift,
    output logic [wmrdtb_pkg::SHIFT_W-1:0]    o_risk_shift
);

    localparam int QW    = wmrdtb_pkg::SHIFT_W;
    localparam int PW    = $clog2(WINDOW_DEPTH);
    localparam int CW    = $clog2(WINDOW_DEPTH + 1);
    localparam int SW    = wmrdtb_pkg::DRIFT_W + CW;
    localparam int DW    = SW + CW;
    localparam int NUMRW = DW + CW + 1;
    localparam int DENW  = 3 * CW + 5;
    localparam int AW    = (DW > DENW) ? DW : DENW;
    localparam int BW    = CW + 5;
    localparam int RATW  = CW + 3 + 15;
    localparam int NUMW  = (NUMRW > RATW) ? NUMRW : RATW;
    localparam int DVW   = (DENW > CW + 4) ? DENW : CW + 4;
    localparam int RW    = (NUMW > DVW + QW) ? NUMW : DVW + QW;

    // window store
    logic [wmrdtb_pkg::ENTRY_W-1:0] r_win [WINDOW_DEPTH];
    logic [wmrdtb_pkg::ENTRY_W-1:0] r_rd_data;
    logic [CW-1:0] r_fill;
    logic [PW-1:0] r_oldest;
    logic [PW-1:0] r_idx;
    logic [PW-1:0] r_rd_lidx;
    logic          r_rd_vld;

    // accumulators
    logic [CW-1:0] r_c, r_e;
    logic [SW-1:0] r_so, r_sr;

    // multiply chain
    logic [DW-1:0]    r_pos, r_neg, r_diff;
    logic             r_trend_pos;
    logic [NUMRW-1:0] r_num;
    logic [DENW-1:0]  r_den;

    // divider
    logic [RW-1:0] r_rem, r_dsh;
    logic [QW-1:0] r_q;
    logic [QW-1:0] r_res_det, r_res_exp, r_res_risk;
    logic [QW-1:0] r_o_det, r_o_exp, r_o_risk;

    function automatic logic [PW-1:0] f_slot(input logic [PW-1:0] base,
                                             input logic [PW-1:0] ofs);
        logic [PW:0] s;
        s = (PW+1)'(base) + (PW+1)'(ofs);
        if (s >= (PW+1)'(WINDOW_DEPTH)) begin
            s = s - (PW+1)'(WINDOW_DEPTH);
        end
        return s[PW-1:0];
    endfunction

    logic [CW-1:0]  n_cnt, mid, rest, max_ce;
    logic           full;
    logic [PW-1:0]  wr_slot;
    logic [wmrdtb_pkg::ENTRY_W-1:0] entry;
    logic [CW+2:0]  c5, e5, n3;
    logic [CW+3:0]  ten_n;
    logic           det_ok, exp_ok, risk_ok;
    logic [AW-1:0]  mul_a;
    logic [BW-1:0]  mul_b;
    logic [AW+BW-1:0] prod;
    logic [RW-1:0]  div_num, div_den;
    logic [QW-1:0]  q_sat;
    logic           res_ok;

    assign n_cnt   = r_fill;
    assign mid     = r_fill >> 1;
    assign rest    = r_fill - mid;
    assign max_ce  = (r_c > r_e) ? r_c : r_e;
    assign full    = (r_fill == CW'(WINDOW_DEPTH));
    assign wr_slot = full ? r_oldest : f_slot(r_oldest, r_fill[PW-1:0]);
    assign entry   = {i_conservative_flag, i_exploratory_flag, i_drift_score};

    assign c5    = (CW+3)'({r_c, 2'b00}) + (CW+3)'(r_c);
    assign e5    = (CW+3)'({r_e, 2'b00}) + (CW+3)'(r_e);
    assign n3    = (CW+3)'({n_cnt, 1'b0}) + (CW+3)'(n_cnt);
    assign ten_n = (CW+4)'({n_cnt, 3'b000}) + (CW+4)'({n_cnt, 1'b0});

    assign det_ok  = c5 > n3;
    assign exp_ok  = e5 > n3;
    assign risk_ok = (n_cnt >= CW'(4)) && r_trend_pos;

    assign o_sts.scan_last = ((CW)'(r_idx) == (n_cnt - 1'b1));

    // window write and scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_win[wr_slot] <= entry;
        end
        if (i_cmd.scan_rd) begin
            r_rd_data <= r_win[f_slot(r_oldest, r_idx)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_oldest <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan_rd;
            if (i_cmd.load) begin
                if (full) begin
                    r_oldest <= f_slot(r_oldest, PW'(1));
                end else begin
                    r_fill <= r_fill + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_idx <= '0;
            r_c   <= '0;
            r_e   <= '0;
            r_so  <= '0;
            r_sr  <= '0;
        end else begin
            if (i_cmd.scan_rd) begin
                r_idx     <= r_idx + 1'b1;
                r_rd_lidx <= r_idx;
            end
            if (r_rd_vld) begin
                r_c <= r_c + CW'(r_rd_data[17]);
                r_e <= r_e + CW'(r_rd_data[16]);
                if (CW'(r_rd_lidx) < mid) begin
                    r_so <= r_so + SW'(r_rd_data[15:0]);
                end else begin
                    r_sr <= r_sr + SW'(r_rd_data[15:0]);
                end
            end
        end
    end

    // shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.arith_op)
            wmrdtb_pkg::OP_POS: begin
                mul_a = AW'(r_sr);
                mul_b = BW'(mid);
            end
            wmrdtb_pkg::OP_NEG: begin
                mul_a = AW'(r_so);
                mul_b = BW'(rest);
            end
            wmrdtb_pkg::OP_NUM: begin
                mul_a = AW'(r_diff);
                mul_b = BW'(n_cnt) + BW'(max_ce);
            end
            wmrdtb_pkg::OP_DEN_A: begin
                mul_a = AW'(n_cnt);
                mul_b = BW'(mid);
            end
            wmrdtb_pkg::OP_DEN_B: begin
                mul_a = AW'(r_den);
                mul_b = BW'(rest);
            end
            wmrdtb_pkg::OP_DEN_C: begin
                mul_a = AW'(r_den);
                mul_b = BW'(20);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = (AW+BW)'(mul_a) * (AW+BW)'(mul_b);

    always_ff @(posedge i_clk) begin
        if (i_cmd.arith_en) begin
            unique case (i_cmd.arith_op)
                wmrdtb_pkg::OP_POS:   r_pos <= prod[DW-1:0];
                wmrdtb_pkg::OP_NEG:   r_neg <= prod[DW-1:0];
                wmrdtb_pkg::OP_DIFF: begin
                    r_trend_pos <= r_pos > r_neg;
                    r_diff      <= (r_pos > r_neg) ? (r_pos - r_neg) : '0;
                end
                wmrdtb_pkg::OP_NUM:   r_num <= prod[NUMRW-1:0];
                wmrdtb_pkg::OP_DEN_A,
                wmrdtb_pkg::OP_DEN_B,
                wmrdtb_pkg::OP_DEN_C: r_den <= prod[DENW-1:0];
                default: begin
                    r_den <= r_den;
                end
            endcase
        end
    end

    // divider operands; unused cases load a zero numerator
    always_comb begin
        div_num = '0;
        div_den = RW'(1);
        unique case (i_cmd.div_sel)
            wmrdtb_pkg::DIV_DET: begin
                div_num = det_ok ? RW'({c5 - n3, 15'b0}) : '0;
                div_den = RW'(ten_n);
            end
            wmrdtb_pkg::DIV_EXP: begin
                div_num = exp_ok ? RW'({e5 - n3, 15'b0}) : '0;
                div_den = RW'(ten_n);
            end
            wmrdtb_pkg::DIV_RISK: begin
                div_num = RW'(r_num);
                div_den = RW'(r_den);
            end
            default: begin
                div_num = '0;
                div_den = RW'(1);
            end
        endcase
    end

    always_comb begin
        unique case (i_cmd.div_sel)
            wmrdtb_pkg::DIV_DET: res_ok = det_ok;
            wmrdtb_pkg::DIV_EXP: res_ok = exp_ok;
            default:             res_ok = risk_ok;
        endcase
    end

    assign q_sat = (r_q > wmrdtb_pkg::SHIFT_MAX) ? wmrdtb_pkg::SHIFT_MAX : r_q;

    // restoring division, one quotient bit per cycle, MSB first
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_rem <= div_num;
            r_dsh <= div_den << (QW - 1);
            r_q   <= '0;
        end else if (i_cmd.div_step) begin
            r_dsh <= r_dsh >> 1;
            if (r_rem >= r_dsh) begin
                r_rem <= r_rem - r_dsh;
                r_q   <= {r_q[QW-2:0], 1'b1};
            end else begin
                r_q   <= {r_q[QW-2:0], 1'b0};
            end
        end
        if (i_cmd.div_store) begin
            unique case (i_cmd.div_sel)
                wmrdtb_pkg::DIV_DET: r_res_det  <= res_ok ? q_sat : '0;
                wmrdtb_pkg::DIV_EXP: r_res_exp  <= res_ok ? q_sat : '0;
                default:             r_res_risk <= res_ok ? q_sat : '0;
            endcase
        end
        if (i_cmd.publish) begin
            r_o_det  <= r_res_det;
            r_o_exp  <= r_res_exp;
            r_o_risk <= r_res_risk;
        end
    end

    assign o_determinism_shift = r_o_det;
    assign o_exploration_shift = r_o_exp;
    assign o_risk_shift        = r_o_risk;

endmodule

@@ sv/window_mode_ratio_drift_trend_bias_core.sv @@
// ----------------------------------------------------------------------------
// window_mode_ratio_drift_trend_bias_core
// Sliding-window mode ratios and drift trend, giving three Q0.15 bias shifts.
// ----------------------------------------------------------------------------
// Sequence: after accept, one memory read per entry of the window fill n after
//   the push, 7 multiply-chain steps, then three 13-bit restoring divisions
//   (load, one quotient bit per step, store) before the result is published.
// Requests do not overlap: a new request is taken only after the previous result
//   has gone to the output register, and it is taken while that result still waits there.
// Reset: synchronous, active low; empties the window and clears all handshakes.
module window_mode_ratio_drift_trend_bias_core #(
    parameter int WINDOW_DEPTH = wmrdtb_pkg::DEFAULT_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request side
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_conservative_flag,
    input  logic                            i_exploratory_flag,
    input  logic [wmrdtb_pkg::DRIFT_W-1:0]  i_drift_score,
    // result side
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [wmrdtb_pkg::SHIFT_W-1:0]  o_determinism_shift,
    output logic [wmrdtb_pkg::SHIFT_W-1:0]  o_exploration_shift,
    output logic [wmrdtb_pkg::SHIFT_W-1:0]  o_risk_shift
);

    // Controller walks: accept -> scan window -> multiply chain
    // (Sr*mid, So*(n-mid), trend, numerator, denominator) -> three divisions
    // -> hand result to the output register.
    wmrdtb_pkg::t_cmd cmd;
    wmrdtb_pkg::t_sts sts;

    wmrdtb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Datapath holds the window memory (registered read), fill count and
    // oldest pointer, accumulators, one shared multiplier and the divider.
    wmrdtb_dp #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .i_conservative_flag (i_conservative_flag),
        .i_exploratory_flag  (i_exploratory_flag),
        .i_drift_score       (i_drift_score),
        .o_determinism_shift (o_determinism_shift),
        .o_exploration_shift (o_exploration_shift),
        .o_risk_shift        (o_risk_shift)
    );

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the window mode and drift bias core. A short table
// of directed requests (short window, wrap, extremes) is followed by random
// runs of biased flags and rising, falling or noisy drift scores. Each result
// is checked field by field against a behavioural window predictor or a
// hand-worked value, while both handshake sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WIN_DEPTH      = wmrdtb_pkg::DEFAULT_DEPTH;
    localparam int DIR_ROWS       = 22;
    localparam int PHASE_REQS     = 400;
    localparam int HOLD_CYCLES    = 500;   // long receiver hold-off
    localparam int TAIL_CYCLES    = 150;   // longer than a full-window request takes
    localparam int WATCHDOG_LIMIT = 4000;

    typedef logic [wmrdtb_pkg::DRIFT_W-1:0] t_drift;
    typedef logic [wmrdtb_pkg::SHIFT_W-1:0] t_shift;

    // one window entry, as the core stores it
    typedef struct packed {
        logic   cons;
        logic   expl;
        t_drift drift;
    } t_win_entry;

    typedef struct packed {
        t_shift det;
        t_shift expl;
        t_shift risk;
    } t_bias_shift;

    // directed row; typed_in marks a hand-worked result
    typedef struct packed {
        logic        cons;
        logic        expl;
        t_drift      drift;
        logic        typed_in;
        t_bias_shift want;
    } t_stim_row;

    logic   i_clk;
    logic   i_rst_n;
    logic   i_in_valid;
    logic   o_in_ready;
    logic   i_conservative_flag;
    logic   i_exploratory_flag;
    t_drift i_drift_score;
    logic   o_out_valid;
    logic   i_out_ready;
    t_shift o_determinism_shift;
    t_shift o_exploration_shift;
    t_shift o_risk_shift;

    window_mode_ratio_drift_trend_bias_core #(
        .WINDOW_DEPTH (WIN_DEPTH)
    ) dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_conservative_flag (i_conservative_flag),
        .i_exploratory_flag  (i_exploratory_flag),
        .i_drift_score       (i_drift_score),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_determinism_shift (o_determinism_shift),
        .o_exploration_shift (o_exploration_shift),
        .o_risk_shift        (o_risk_shift)
    );

    // ------------------------------------------------------------------------
    // Directed requests. The first four are worked by hand:
    //   1: n=1, c=1         -> det saturates, no trend yet
    //   2: n=2, c=e=1       -> ratio 0.5, nothing
    //   3: n=3, c=e=2       -> 32768/30 = 1092 on both ratios
    //   4: n=4, older half 0, newer half full scale, M=2
    //      -> 262140*6/320 = 4915 risk, ratios at 0.5
    // The rest fill the window, wrap it, and swing the trend both ways.
    // ------------------------------------------------------------------------
    t_stim_row directed_rows [DIR_ROWS] = '{
        '{1'b1, 1'b0, 16'h0000, 1'b1, '{13'd6553, 13'd0,    13'd0}},
        '{1'b0, 1'b1, 16'h0000, 1'b1, '{13'd0,    13'd0,    13'd0}},
        '{1'b1, 1'b1, 16'hFFFF, 1'b1, '{13'd1092, 13'd1092, 13'd0}},
        '{1'b0, 1'b0, 16'hFFFF, 1'b1, '{13'd0,    13'd0,    13'd4915}},
        '{1'b1, 1'b1, 16'hFFFF, 1'b0, '{13'd0, 13'd0, 13'd0}},
        '{1'b1, 1'b1, 16'hFFFF, 1'b0, '{13'd0, 13'd0, 13'd0}},
        '{1'b1, 1'b0, 16'h8000, 1'b0, '{13'd0, 13'd0, 13'd0}},
        '{1'b1, 1'b0, 16'h7FFF, 1'b0, '{13'd0, 13'd0, 13'd0}},
        '{1'b0, 1'b1, 16'h0001, 1'b0, '{13'd0, 13'd0, 13'd0}},
        '{1'b0, 1'b1, 16'hFFFE, 1'b0, '{13'd0, 13'd0, 13'd0}},
        '{1'b1, 1'b1, 16'hAAAA, 1'b0, '{13'd0, 13'd0, 13'd0}},
        '{1'b1, 1'b1, 16'h5555, 1'b0, '{13'd0, 13'd0, 13'd0}},
        '{1'b1, 1'b1, 16'h0000, 1'b0, '{13'd0, 13'd0, 13'd0}},
        '{1'b1, 1'b1, 16'h0000, 1'b0, '{13'd0, 13'd0, 13'd0}},
        '{1'b1, 1'b1, 16'h0000, 1'b0, '{13'd0, 13'd0, 13'd0}},
        '{1'b1, 1'b1, 16'h0000, 1'b0, '{13'd0, 13'd0, 13'd0}},
        '{1'b1, 1'b1, 16'h0000, 1'b0, '{13'd0, 13'd0, 13'd0}},
        '{1'b0, 1'b0, 16'hFFFF, 1'b0, '{13'd0, 13'd0, 13'd0}},
        '{1'b0, 1'b1, 16'hFFFF, 1'b0, '{13'd0, 13'd0, 13'd0}},
        '{1'b0, 1'b0, 16'h1234, 1'b0, '{13'd0, 13'd0, 13'd0}},
        '{1'b1, 1'b0, 16'h0000, 1'b0, '{13'd0, 13'd0, 13'd0}},
        '{1'b0, 1'b0, 16'h0000, 1'b0, '{13'd0, 13'd0, 13'd0}}
    };

    // predictor copy of the window
    t_win_entry  win_model [WIN_DEPTH];
    int unsigned win_fill;
    int unsigned win_oldest;

    t_bias_shift pending_shifts [$];   // expected results, oldest first
    int          mismatch_count;

    // what goes with the request currently on the bus
    logic        req_typed_in;
    t_bias_shift req_want;

    // idle percentages and the receiver hold-off trigger
    int tx_idle_pct;
    int rx_idle_pct;
    bit hold_request;

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    // (ratio - 0.6) / 0.4 * 0.2 in Q0.15, i.e. 32768 * (5k - 3n) / (10n)
    function automatic t_shift mode_ratio_shift(longint unsigned k,
                                                longint unsigned n);
        longint unsigned q;
        if (5 * k <= 3 * n)
            return '0;
        q = (64'd32768 * (5 * k - 3 * n)) / (10 * n);
        return (q > wmrdtb_pkg::SHIFT_MAX) ? wmrdtb_pkg::SHIFT_MAX
                                           : q[wmrdtb_pkg::SHIFT_W-1:0];
    endfunction

    // put one entry into the window and work out the three shifts
    function automatic t_bias_shift add_and_predict(t_win_entry ent);
        t_bias_shift     res;
        t_win_entry      w;
        longint unsigned n, mid, c, e, m, so, sr, pos, neg, q;
        c  = 0;
        e  = 0;
        so = 0;
        sr = 0;
        if (win_fill < WIN_DEPTH) begin
            win_model[(win_oldest + win_fill) % WIN_DEPTH] = ent;
            win_fill++;
        end else begin
            // full window: overwrite the oldest and move on
            win_model[win_oldest] = ent;
            win_oldest = (win_oldest + 1) % WIN_DEPTH;
        end
        n   = win_fill;
        mid = n / 2;
        for (int unsigned i = 0; i < win_fill; i++) begin
            w  = win_model[(win_oldest + i) % WIN_DEPTH];
            c += w.cons;
            e += w.expl;
            if (i < mid)
                so += w.drift;
            else
                sr += w.drift;
        end
        res.det  = mode_ratio_shift(c, n);
        res.expl = mode_ratio_shift(e, n);
        res.risk = '0;
        if (n >= 4) begin
            pos = sr * mid;
            neg = so * (n - mid);
            if (pos > neg) begin
                m = (c > e) ? c : e;
                q = ((pos - neg) * (n + m)) / (20 * n * mid * (n - mid));
                res.risk = (q > wmrdtb_pkg::SHIFT_MAX) ? wmrdtb_pkg::SHIFT_MAX
                                                       : q[wmrdtb_pkg::SHIFT_W-1:0];
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] %s", $time, msg);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Scoreboard: results are checked before the new request is predicted
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_bias_shift want;
        t_bias_shift model;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_shifts.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                want = pending_shifts[0];
                pending_shifts.delete(0);
                if (o_determinism_shift !== want.det)
                    report_mismatch($sformatf("determinism_shift: got %0d, want %0d",
                                              o_determinism_shift, want.det));
                if (o_exploration_shift !== want.expl)
                    report_mismatch($sformatf("exploration_shift: got %0d, want %0d",
                                              o_exploration_shift, want.expl));
                if (o_risk_shift !== want.risk)
                    report_mismatch($sformatf("risk_shift: got %0d, want %0d",
                                              o_risk_shift, want.risk));
            end
        end
        if (i_rst_n && i_in_valid && o_in_ready) begin
            model = add_and_predict('{i_conservative_flag, i_exploratory_flag,
                                      i_drift_score});
            pending_shifts.insert(pending_shifts.size(),
                                  req_typed_in ? req_want : model);
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls, or a long hold-off when asked for
    // ------------------------------------------------------------------------
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_request = 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run if neither side moves for too long
    // ------------------------------------------------------------------------
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sender. Called at a falling edge; returns at the falling edge after the
    // request is taken. Valid is only lowered when an idle cycle is drawn.
    // ------------------------------------------------------------------------
    task automatic offer_request(logic cons, logic expl, t_drift drift,
                                 logic typed_in, t_bias_shift want);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_conservative_flag <= cons;
        i_exploratory_flag  <= expl;
        i_drift_score       <= drift;
        req_typed_in         = typed_in;
        req_want             = want;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int     run_left;
        int     cons_pct;
        int     expl_pct;
        int     drift_mode;
        int     step;
        t_drift drift;
        logic   cons;
        logic   expl;

        i_rst_n             = 1'b0;
        i_in_valid          = 1'b0;
        i_conservative_flag = 1'b0;
        i_exploratory_flag  = 1'b0;
        i_drift_score       = '0;
        req_typed_in        = 1'b0;
        req_want            = '0;
        hold_request        = 1'b0;
        mismatch_count      = 0;
        win_fill            = 0;
        win_oldest          = 0;
        tx_idle_pct         = 38;
        rx_idle_pct         = 60;
        run_left            = 0;
        cons_pct            = 50;
        expl_pct            = 50;
        drift_mode          = 0;
        drift               = '0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table
        for (int r = 0; r < DIR_ROWS; r++)
            offer_request(directed_rows[r].cons, directed_rows[r].expl,
                          directed_rows[r].drift, directed_rows[r].typed_in,
                          directed_rows[r].want);

        // random runs; three idle phases
        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin
                tx_idle_pct = 60;
                rx_idle_pct = 38;
            end else if (ph == 2) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            // sender pause: let the core drain completely between phases
            if (ph != 0) begin
                i_in_valid <= 1'b0;
                while (pending_shifts.size() != 0 || hold_request)
                    @(negedge i_clk);
            end
            // receiver goes quiet while requests keep coming, so the core
            // backs up and stalls its input
            if (ph != 1)
                hold_request = 1'b1;

            for (int k = 0; k < PHASE_REQS; k++) begin
                if (run_left == 0) begin
                    // new run: flag bias and drift shape
                    run_left = $urandom_range(4, 40);
                    case ($urandom_range(0, 4))
                        0: cons_pct = 5;
                        1: cons_pct = 50;
                        2: cons_pct = 80;
                        3: cons_pct = 95;
                        default: cons_pct = 100;
                    endcase
                    case ($urandom_range(0, 4))
                        0: expl_pct = 0;
                        1: expl_pct = 30;
                        2: expl_pct = 70;
                        3: expl_pct = 90;
                        default: expl_pct = 100;
                    endcase
                    drift_mode = $urandom_range(0, 3);
                    drift      = t_drift'($urandom_range(0, 16'hFFFF));
                end
                run_left--;
                cons = ($urandom_range(0, 99) < cons_pct);
                expl = ($urandom_range(0, 99) < expl_pct);
                step = $urandom_range(0, 6000);
                case (drift_mode)
                    1: drift = (drift > 16'hFFFF - step) ? 16'hFFFF
                                                         : t_drift'(drift + step);
                    2: drift = (drift < step) ? 16'h0000 : t_drift'(drift - step);
                    3: drift = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
                    default: drift = t_drift'($urandom_range(0, 16'hFFFF));
                endcase
                offer_request(cons, expl, drift, 1'b0, '0);
            end
        end

        // drain and settle
        i_in_valid <= 1'b0;
        while (pending_shifts.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ sim.f @@
sv/wmrdtb_pkg.sv
sv/wmrdtb_ctrl.sv
sv/wmrdtb_dp.sv
sv/window_mode_ratio_drift_trend_bias_core.sv
tb/sv/tb_top.sv
